// ----- hdl/cas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_pkg: shared definitions for the compacting array store
// Field widths, request and status codes, the control-state type and the
// per-cell control group.
// ----------------------------------------------------------------------------
package cas_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths on the stream ports.
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 10;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Request codes; codes above the count query also act as a count query.
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Control state: idle and ready, or waiting on the read tree.
  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } cas_state_t;

  // Operation strobe broadcast to every cell for one cycle.
  typedef struct packed {
    logic append;
    logic remove;
    logic write;
  } cas_op_t;

endpackage
`default_nettype wire

// ----- hdl/compacting_array_store_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_array_store_unit: ordered store with in-place compaction
// Append, remove with gap closing, read, overwrite and count query.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells, one entry each. A request is taken on
// the slave stream, applied to all cells in the next cycle (a removal moves
// every later entry down one cell at once), and its single result leaves on
// the master stream. Reads pass through a registered OR tree of
// log2(CAPACITY) levels, rounded up; every mode waits for that tree before
// its result is issued and the next request is taken. A finished result
// waits in the output register while the next request is already taken.
// Remove, read and overwrite indexes at or beyond the count give status 1
// and change nothing; an append to a full store gives status 2. Entries hold
// no reset value; only written positions are ever read.
// ----------------------------------------------------------------------------
module compacting_array_store_unit #(
  parameter int CAPACITY    = cas_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cas_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Fields from bit 0 up: mode[2:0], index[12:3], value[44:13], zero pad.
  input  wire logic [cas_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0 up: read_value[31:0], count[42:32], status[44:43], pad.
  output logic      [cas_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready
);
  import cas_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int VW    = VALUE_WIDTH;
  localparam int LAT   = $clog2(CAPACITY);
  localparam int WCW   = $clog2(LAT + 1);
  localparam int XW    = CW + INDEX_W;
  localparam logic [CW-1:0]  CAP_C = CW'(CAPACITY);
  localparam logic [WCW-1:0] LAT_C = WCW'(LAT);

  // Input field split.
  logic [MODE_W-1:0]  in_mode;
  logic [INDEX_W-1:0] in_index;
  logic [DATA_W-1:0]  in_value;

  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_index = s_tdata[MODE_W+INDEX_W-1:MODE_W];
  assign in_value = s_tdata[MODE_W+INDEX_W+DATA_W-1:MODE_W+INDEX_W];

  // Control and request registers.
  cas_state_t        state, state_next;
  logic [WCW-1:0]    wait_cnt;
  logic [CW-1:0]     cnt;
  cas_op_t           op;
  logic [CW-1:0]     req_idx;
  logic [VW-1:0]     req_val;
  logic              rd_ok;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]     res_count;

  logic              in_fire, out_free, done;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign done     = (state == ST_BUSY) && (wait_cnt == '0) && out_free;

  // Request decode against the current count.
  logic [XW-1:0]       idx_x, cnt_x;
  logic                in_range, full;
  cas_op_t             op_next;
  logic                rd_ok_next;
  logic [STATUS_W-1:0] status_next;
  logic [CW-1:0]       count_next;
  logic [DATA_W+VW-1:0] val_x;

  assign idx_x    = {{CW{1'b0}}, in_index};
  assign cnt_x    = {{INDEX_W{1'b0}}, cnt};
  assign in_range = idx_x < cnt_x;
  assign full     = (cnt == CAP_C);
  assign val_x    = {{VW{1'b0}}, in_value};

  always_comb begin
    op_next     = '0;
    rd_ok_next  = 1'b0;
    status_next = STATUS_OK;
    count_next  = cnt;
    case (in_mode)
      MODE_APPEND: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          op_next.append = 1'b1;
          count_next     = cnt + CW'(1);
        end
      end
      MODE_REMOVE: begin
        if (!in_range) begin
          status_next = STATUS_RANGE;
        end else begin
          op_next.remove = 1'b1;
          count_next     = cnt - CW'(1);
        end
      end
      MODE_READ: begin
        if (!in_range) begin
          status_next = STATUS_RANGE;
        end else begin
          rd_ok_next = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (!in_range) begin
          status_next = STATUS_RANGE;
        end else begin
          op_next.write = 1'b1;
        end
      end
      MODE_COUNT: begin
        status_next = STATUS_OK;
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_BUSY: s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  // Control registers: state, tree wait, count and the cell strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wait_cnt <= '0;
      cnt      <= '0;
      op       <= '0;
    end else begin
      state <= state_next;
      op    <= in_fire ? op_next : '0;
      if (in_fire) begin
        wait_cnt <= LAT_C;
      end else if ((state == ST_BUSY) && (wait_cnt != '0)) begin
        wait_cnt <= wait_cnt - WCW'(1);
      end
      if (op.append) begin
        cnt <= cnt + CW'(1);
      end else if (op.remove) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Request payload held for the cells and the result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_idx    <= idx_x[CW-1:0];
      req_val    <= val_x[VW-1:0];
      rd_ok      <= rd_ok_next;
      res_status <= status_next;
      res_count  <= count_next;
    end
  end

  // Row of cells; on removal, cells from the index up copy the cell above.
  logic [VW-1:0] cell_q [CAPACITY+1];
  logic [VW-1:0] leaf   [CAPACITY];

  assign cell_q[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cas_cell #(
      .VW  (VW),
      .CW  (CW),
      .POS (i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .idx     (req_idx),
      .cnt     (cnt),
      .wdata   (req_val),
      .up_data (cell_q[i+1]),
      .data    (cell_q[i]),
      .leaf    (leaf[i])
    );
  end

  // Read path through the registered tree.
  logic [VW-1:0] rd_root;

  cas_rd_tree #(
    .WIDTH  (VW),
    .LEAVES (CAPACITY)
  ) u_rd_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (rd_root)
  );

  // Output register.
  logic [VW+DATA_W-1:0]      rd_x;
  logic [CW+COUNT_W-1:0]     cnt_out_x;
  logic [DATA_W-1:0]         rd_value;

  assign rd_x      = {{DATA_W{1'b0}}, rd_root};
  assign cnt_out_x = {{COUNT_W{1'b0}}, res_count};
  assign rd_value  = rd_ok ? rd_x[DATA_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {{(OUT_TDATA_W-DATA_W-COUNT_W-STATUS_W){1'b0}},
                  res_status, cnt_out_x[COUNT_W-1:0], rd_value};
    end
  end

  // Assertions.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_C)
    else $error("entry count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_BUSY) && (wait_cnt == LAT_C))
    else $error("accepted request did not start the read wait");

  a_strobe_once: assert property (@(posedge clk) disable iff (rst)
    (op != '0) |-> $past(in_fire) && $onehot(op))
    else $error("cell strobe not a single pulse after acceptance");

  a_result_after_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_BUSY) && $past(wait_cnt == '0))
    else $error("result issued before the read tree settled");

endmodule
`default_nettype wire

// ----- hdl/cas_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_cell: one entry of the store
// Holds the entry at a fixed position, loads it on append or overwrite, takes
// its upper neighbor's entry when a removal closes the gap, and offers the
// entry to the read tree when the request index selects it.
// ----------------------------------------------------------------------------
module cas_cell #(
  parameter int VW  = 32,
  parameter int CW  = 11,
  parameter int POS = 0
) (
  input  wire logic             clk,
  input  wire cas_pkg::cas_op_t op,
  input  wire logic [CW-1:0]    idx,
  input  wire logic [CW-1:0]    cnt,
  input  wire logic [VW-1:0]    wdata,
  input  wire logic [VW-1:0]    up_data,
  output logic      [VW-1:0]    data,
  output logic      [VW-1:0]    leaf
);
  import cas_pkg::*;

  localparam logic [CW-1:0] POS_C  = CW'(POS);
  localparam logic [CW-1:0] POS_P1 = CW'(POS + 1);

  logic [VW-1:0] data_next;
  logic          hit;

  assign hit = (idx == POS_C);

  // Entry update: overwrite, append at the end, or shift down on removal.
  always_comb begin
    data_next = data;
    if (op.write && hit) begin
      data_next = wdata;
    end else if (op.append && (cnt == POS_C)) begin
      data_next = wdata;
    end else if (op.remove && (idx <= POS_C) && (POS_P1 < cnt)) begin
      data_next = up_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only the selected cell drives a nonzero leaf.
  assign leaf = hit ? data : '0;

endmodule
`default_nettype wire

// ----- hdl/cas_rd_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_rd_tree: pipelined OR tree over the cell leaves
// A binary tree with a register at every inner node; at most one leaf is
// nonzero, so the root carries the selected entry once it has passed
// through every register level.
// ----------------------------------------------------------------------------
module cas_rd_tree #(
  parameter int WIDTH  = 32,
  parameter int LEAVES = 1024
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] leaf [LEAVES],
  output logic      [WIDTH-1:0] root
);
  import cas_pkg::*;

  localparam int N = 1 << $clog2(LEAVES);

  logic [WIDTH-1:0] nodes [1:2*N-1];

  // Leaf row, padded with zeros up to a power of two.
  for (genvar j = 0; j < N; j++) begin : g_leaf
    if (j < LEAVES) begin : g_used
      assign nodes[N+j] = leaf[j];
    end else begin : g_pad
      assign nodes[N+j] = '0;
    end
  end

  // Registered inner nodes.
  for (genvar k = 1; k < N; k++) begin : g_node
    always_ff @(posedge clk) begin
      nodes[k] <= nodes[2*k] | nodes[2*k+1];
    end
  end

  assign root = nodes[1];

endmodule
`default_nettype wire
